// File: src/lbph_pkg.sv
// Shared constants for the 3x3 local binary pattern histogram unit.
`timescale 1ns / 1ps

package lbph_pkg;

    localparam int PIX_W      = 8;
    localparam int CODE_W     = 8;
    localparam int BIN_W      = 8;
    localparam int NUM_BINS   = 256;
    localparam int DELTA_W    = 9;
    localparam int RWIDTH_W   = 11;
    localparam int RHEIGHT_W  = 13;
    localparam int ROW_W      = 12;
    localparam int MAX_HEIGHT = 4096;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 13;
    localparam int IN_DATA_W  = 16;
    localparam int IN_USER_W  = 2;

    // Configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_DELTA      = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_ROI_WIDTH  = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_ROI_HEIGHT = 2'd2;

    // Input item kinds
    localparam logic ACT_PIXEL = 1'b0;
    localparam logic ACT_READ  = 1'b1;

    localparam logic [DELTA_W-1:0]   DELTA_RST      = 9'd0;
    localparam logic [RWIDTH_W-1:0]  ROI_WIDTH_RST  = 11'd640;
    localparam logic [RHEIGHT_W-1:0] ROI_HEIGHT_RST = 13'd480;

endpackage

// File: src/lbp_histogram_3x3_unit.sv
// Top level: streamed 3x3 local binary pattern histogram with bin read-out.
//
//  channel   | direction | tdata (low bit up)                | tuser / tlast
//  ----------+-----------+-----------------------------------+--------------------------
//  s_axis    | in        | pixel[7:0], bin_index[15:8]       | action[0], start_of_frame[1]
//  m_axis    | out       | lbp_code[7:0], bin_count[8 +: CB] | code_valid[0]; frame_done
//  cfg       | in        | 0 delta, 1 roi_width, 2 roi_height| write only
//
// One transfer is taken per cycle while input is not held off; a result passes
// through the stage 1, stage 2 and output registers. The histogram read-modify-write
// reads memory in stage 1 and writes back in stage 2, forwarding between neighbours.
// Reset clears the histogram at once through per-bin valid flags; there is no
// clearing pass. Input is held off only when the output register and the last
// stage both hold a result that the downstream side does not take.
`timescale 1ns / 1ps

module lbp_histogram_3x3_unit #(
    parameter int MAX_WIDTH  = 1024,
    parameter int COUNT_BITS = 24
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     cfg_we,
    input  logic [lbph_pkg::CFG_ADDR_W-1:0]          cfg_addr,
    input  logic [lbph_pkg::CFG_DATA_W-1:0]          cfg_wdata,
    input  logic                                     s_axis_tvalid,
    output logic                                     s_axis_tready,
    // pixel[7:0], bin_index[15:8]
    input  logic [lbph_pkg::IN_DATA_W-1:0]           s_axis_tdata,
    // action[0], start_of_frame[1]
    input  logic [lbph_pkg::IN_USER_W-1:0]           s_axis_tuser,
    output logic                                     m_axis_tvalid,
    input  logic                                     m_axis_tready,
    // lbp_code[7:0], bin_count[8 +: COUNT_BITS], zero fill to whole bytes
    output logic [((lbph_pkg::CODE_W + COUNT_BITS + 7) / 8) * 8 - 1:0] m_axis_tdata,
    // code_valid[0]
    output logic                                     m_axis_tuser,
    output logic                                     m_axis_tlast
);

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int WID_W = $clog2(MAX_WIDTH + 1);
    localparam int CMP_W = (WID_W > lbph_pkg::RWIDTH_W) ? WID_W : lbph_pkg::RWIDTH_W;
    localparam int OUT_W = ((lbph_pkg::CODE_W + COUNT_BITS + 7) / 8) * 8;
    localparam int PW    = lbph_pkg::PIX_W;
    localparam int HW    = lbph_pkg::RHEIGHT_W;

    // Configuration registers
    logic [lbph_pkg::DELTA_W-1:0]   delta_reg;
    logic [lbph_pkg::RWIDTH_W-1:0]  roi_width_reg;
    logic [HW-1:0]                  roi_height_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delta_reg      <= lbph_pkg::DELTA_RST;
            roi_width_reg  <= lbph_pkg::ROI_WIDTH_RST;
            roi_height_reg <= lbph_pkg::ROI_HEIGHT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                lbph_pkg::CFG_DELTA:      delta_reg <= cfg_wdata[lbph_pkg::DELTA_W-1:0];
                lbph_pkg::CFG_ROI_WIDTH:  roi_width_reg <= cfg_wdata[lbph_pkg::RWIDTH_W-1:0];
                lbph_pkg::CFG_ROI_HEIGHT: roi_height_reg <= cfg_wdata;
                default:                  ;
            endcase
        end
    end

    // Pipeline control
    logic s1_valid_reg, s2_valid_reg, out_valid_reg;
    logic adv, in_xfer;

    assign adv           = !s2_valid_reg || !out_valid_reg || m_axis_tready;
    assign s_axis_tready = adv;
    assign in_xfer       = s_axis_tvalid && adv;

    // Stage 0: position tracking and line store address
    logic              in_act, in_sof;
    logic [PW-1:0]     in_pix;
    logic [lbph_pkg::BIN_W-1:0] in_bin;

    assign in_act = s_axis_tuser[0];
    assign in_sof = s_axis_tuser[1];
    assign in_pix = s_axis_tdata[PW-1:0];
    assign in_bin = s_axis_tdata[PW +: lbph_pkg::BIN_W];

    logic [COL_W-1:0]          col_reg, col_cur, col_next;
    logic [lbph_pkg::ROW_W-1:0] row_reg, row_cur, row_next;
    logic [CMP_W-1:0]          rw_ext, width_cmp;
    logic [WID_W-1:0]          width_eff;
    logic [HW-1:0]             height_eff;
    logic [COL_W-1:0]          col_clamped;
    logic [lbph_pkg::ROW_W-1:0] row_clamped;
    logic                      col_last, row_last, interior0, done0;

    always_comb
    begin
        rw_ext = CMP_W'(roi_width_reg);
        if (rw_ext == '0)
            width_cmp = CMP_W'(1);
        else if (rw_ext > CMP_W'(MAX_WIDTH))
            width_cmp = CMP_W'(MAX_WIDTH);
        else
            width_cmp = rw_ext;
        width_eff = WID_W'(width_cmp);

        if (roi_height_reg == '0)
            height_eff = HW'(1);
        else if (roi_height_reg > HW'(lbph_pkg::MAX_HEIGHT))
            height_eff = HW'(lbph_pkg::MAX_HEIGHT);
        else
            height_eff = roi_height_reg;

        // A position left beyond a narrower region sticks to its last column or row.
        if (WID_W'(col_reg) >= width_eff)
            col_clamped = COL_W'(width_eff - WID_W'(1));
        else
            col_clamped = col_reg;
        if (HW'(row_reg) >= height_eff)
            row_clamped = lbph_pkg::ROW_W'(height_eff - HW'(1));
        else
            row_clamped = row_reg;

        col_cur = in_sof ? '0 : col_clamped;
        row_cur = in_sof ? '0 : row_clamped;

        col_last  = (WID_W'(col_cur) + WID_W'(1)) >= width_eff;
        row_last  = (HW'(row_cur) + HW'(1)) >= height_eff;
        interior0 = (row_cur >= lbph_pkg::ROW_W'(2)) && (col_cur >= COL_W'(2));
        done0     = col_last && row_last;

        if (col_last)
        begin
            col_next = '0;
            row_next = row_last ? '0 : row_cur + lbph_pkg::ROW_W'(1);
        end
        else
        begin
            col_next = col_cur + COL_W'(1);
            row_next = row_cur;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (in_xfer && in_act == lbph_pkg::ACT_PIXEL)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // Stage 1 registers
    logic                       s1_act_reg, s1_int_reg, s1_done_reg, s1_sof_reg;
    logic [PW-1:0]              s1_pix_reg;
    logic [lbph_pkg::BIN_W-1:0] s1_bin_reg;
    logic [COL_W-1:0]           s1_idx_reg;
    logic                       lfwd_reg;
    logic [2*PW-1:0]            lfwd_data_reg;
    logic [2*PW-1:0]            line_rd_reg;
    logic [2*PW-1:0]            line_mem [MAX_WIDTH];

    logic [PW-1:0] t1, m1;
    logic          s1_pixel, line_we, lfwd_next;

    assign {t1, m1}  = lfwd_reg ? lfwd_data_reg : line_rd_reg;
    assign s1_pixel  = s1_valid_reg && s1_act_reg == lbph_pkg::ACT_PIXEL;
    assign line_we   = adv && s1_pixel;
    assign lfwd_next = in_xfer && in_act == lbph_pkg::ACT_PIXEL && s1_pixel
                       && s1_idx_reg == col_cur;

    // Both line stores share one address, so they live in one memory:
    // upper row in the high byte, middle row in the low byte.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            line_rd_reg <= line_mem[col_cur];
            if (line_we)
                line_mem[s1_idx_reg] <= {m1, s1_pix_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            lfwd_reg     <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= in_xfer;
            lfwd_reg     <= lfwd_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_act_reg    <= in_act;
            s1_int_reg    <= interior0;
            s1_done_reg   <= done0;
            s1_sof_reg    <= in_sof;
            s1_pix_reg    <= in_pix;
            s1_bin_reg    <= in_bin;
            s1_idx_reg    <= col_cur;
            lfwd_data_reg <= {m1, s1_pix_reg};
        end
    end

    // Window: columns n-2 and n-1 of the upper, middle and lower rows
    logic [PW-1:0] win_reg [6];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 6; i++)
                win_reg[i] <= '0;
        end
        else if (line_we)
        begin
            win_reg[0] <= win_reg[1];
            win_reg[1] <= t1;
            win_reg[2] <= win_reg[3];
            win_reg[3] <= m1;
            win_reg[4] <= win_reg[5];
            win_reg[5] <= s1_pix_reg;
        end
    end

    // Code formation: each neighbour against centre plus delta, 10-bit signed.
    logic signed [PW+1:0]       thresh;
    logic [lbph_pkg::CODE_W-1:0] code1;
    logic [PW-1:0]              nb [8];
    logic [lbph_pkg::BIN_W-1:0] haddr1;

    always_comb
    begin
        thresh = $signed({2'b00, win_reg[3]})
                 + $signed({delta_reg[lbph_pkg::DELTA_W-1], delta_reg});
        nb[0] = win_reg[0];
        nb[1] = win_reg[1];
        nb[2] = t1;
        nb[3] = win_reg[2];
        nb[4] = m1;
        nb[5] = win_reg[4];
        nb[6] = win_reg[5];
        nb[7] = s1_pix_reg;
        for (int k = 0; k < 8; k++)
            code1[k] = $signed({2'b00, nb[k]}) > thresh;
        haddr1 = (s1_act_reg == lbph_pkg::ACT_READ) ? s1_bin_reg : code1;
    end

    // Stage 2: histogram read-modify-write
    logic                       s2_act_reg, s2_cv_reg, s2_done_reg, s2_sof_reg;
    logic [lbph_pkg::CODE_W-1:0] s2_code_reg;
    logic [lbph_pkg::BIN_W-1:0] s2_addr_reg;
    logic                       hfwd_reg;
    logic [COUNT_BITS-1:0]      hfwd_data_reg;
    logic [COUNT_BITS-1:0]      hist_rd_reg;
    logic [COUNT_BITS-1:0]      hist_mem [lbph_pkg::NUM_BINS];
    logic [lbph_pkg::NUM_BINS-1:0] hvalid_reg;

    logic [COUNT_BITS-1:0] cur2, hist_new;
    logic                  s2_pixel, hist_we, hfwd_next;

    assign s2_pixel  = s2_valid_reg && s2_act_reg == lbph_pkg::ACT_PIXEL;
    assign hist_we   = adv && s2_pixel && s2_cv_reg;
    assign hfwd_next = s2_pixel && s2_cv_reg && s2_addr_reg == haddr1;
    assign cur2      = hfwd_reg ? hfwd_data_reg
                     : (hvalid_reg[s2_addr_reg] ? hist_rd_reg : '0);
    assign hist_new  = (cur2 == '1) ? cur2 : cur2 + COUNT_BITS'(1);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            hist_rd_reg <= hist_mem[haddr1];
            if (hist_we)
                hist_mem[s2_addr_reg] <= hist_new;
        end
    end

    // A start of frame on a pixel clears the bins as it passes this stage, so older items
    // finish on the old counts and younger ones see an empty histogram.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hvalid_reg   <= '0;
            s2_valid_reg <= 1'b0;
            hfwd_reg     <= 1'b0;
        end
        else if (adv)
        begin
            s2_valid_reg <= s1_valid_reg;
            hfwd_reg     <= hfwd_next;
            if (s2_pixel && s2_sof_reg)
                hvalid_reg <= '0;
            else if (hist_we)
                hvalid_reg[s2_addr_reg] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_act_reg    <= s1_act_reg;
            s2_cv_reg     <= s1_int_reg;
            s2_done_reg   <= s1_done_reg;
            s2_sof_reg    <= s1_sof_reg;
            s2_code_reg   <= s1_int_reg ? code1 : '0;
            s2_addr_reg   <= haddr1;
            hfwd_data_reg <= hist_new;
        end
    end

    // Output register
    logic                        out_cv_reg, out_done_reg;
    logic [lbph_pkg::CODE_W-1:0] out_code_reg;
    logic [COUNT_BITS-1:0]       out_bin_reg;
    logic                        load_out;

    assign load_out = adv && s2_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (load_out)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_cv_reg   <= s2_pixel && s2_cv_reg;
            out_code_reg <= s2_pixel ? s2_code_reg : '0;
            out_done_reg <= s2_pixel && s2_done_reg;
            out_bin_reg  <= s2_pixel ? '0 : cur2;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_W'({out_bin_reg, out_code_reg});
    assign m_axis_tuser  = out_cv_reg;
    assign m_axis_tlast  = out_done_reg;

endmodule

// File: src/lbph_checker.sv
// Port-level checks for the local binary pattern histogram unit, with its bind.
`timescale 1ns / 1ps

module lbph_checker #(
    parameter int COUNT_BITS = 24
) (
    input logic                                     clk,
    input logic                                     rst_n,
    input logic                                     m_axis_tvalid,
    input logic                                     m_axis_tready,
    input logic [((lbph_pkg::CODE_W + COUNT_BITS + 7) / 8) * 8 - 1:0] m_axis_tdata,
    input logic                                     m_axis_tuser,
    input logic                                     m_axis_tlast
);

    // A result that is not taken stays as it is.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
            && $stable(m_axis_tlast))
        else $error("output transfer changed while stalled");

    // Without a counted window the code field is zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[lbph_pkg::CODE_W-1:0] == '0)
        else $error("code present without code_valid");

    // A bin count only comes back on a read, which never carries pixel flags.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[lbph_pkg::CODE_W +: COUNT_BITS] != '0 |->
            !m_axis_tuser && !m_axis_tlast)
        else $error("bin count on a pixel result");

    // A bin read-out cannot share one result with a code.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[lbph_pkg::CODE_W +: COUNT_BITS] == '0)
        else $error("counted window carries a bin count");

endmodule

bind lbp_histogram_3x3_unit lbph_checker #(
    .COUNT_BITS(COUNT_BITS)
) u_lbph_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

// File: tb/tb_lbp_histogram_3x3_unit.sv
// Self-checking testbench for the streamed 3x3 local binary pattern histogram unit.
`timescale 1ns / 1ps

module tb_lbp_histogram_3x3_unit;

    import lbph_pkg::*;

    localparam int MAX_W        = 1024;
    localparam int COUNT_BITS   = 24;
    localparam int OUT_W        = ((CODE_W + COUNT_BITS + 7) / 8) * 8;
    localparam int SETTLE_TICKS = 8;
    localparam int NUM_PHASES   = 14;
    localparam int MAX_REPORTS  = 40;

    typedef struct {
        bit                  code_valid;
        bit [CODE_W-1:0]     lbp_code;
        bit                  frame_done;
        bit [COUNT_BITS-1:0] bin_count;
    } lbp_result_t;

    // Holds a private copy of the unit's state, predicts each result and
    // compares the results that come out against them in order.
    class lbp_scoreboard;
        bit [PIX_W-1:0]      above_line [MAX_W];
        bit [PIX_W-1:0]      near_line  [MAX_W];
        bit [PIX_W-1:0]      top_win [2];
        bit [PIX_W-1:0]      mid_win [2];
        bit [PIX_W-1:0]      bot_win [2];
        int                  cur_col;
        int                  cur_row;
        bit [COUNT_BITS-1:0] bin_tally [NUM_BINS];
        logic signed [DELTA_W-1:0] delta_reg;
        logic [RWIDTH_W-1:0]       roi_w;
        logic [RHEIGHT_W-1:0]      roi_h;
        lbp_result_t         pending_results [$];
        bit [CODE_W-1:0]     last_code;
        int                  errors;
        int                  n_checked;
        int                  n_codes;
        int                  n_frames;

        function new();
            cur_col   = 0;
            cur_row   = 0;
            delta_reg = DELTA_RST;
            roi_w     = ROI_WIDTH_RST;
            roi_h     = ROI_HEIGHT_RST;
            last_code = '0;
            errors    = 0;
            n_checked = 0;
            n_codes   = 0;
            n_frames  = 0;
        endfunction

        function void set_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_DELTA:      delta_reg = val[DELTA_W-1:0];
                CFG_ROI_WIDTH:  roi_w     = val[RWIDTH_W-1:0];
                CFG_ROI_HEIGHT: roi_h     = val[RHEIGHT_W-1:0];
                default: ;
            endcase
        endfunction

        function void add_item(logic act, logic sof, logic [PIX_W-1:0] pix,
                               logic [BIN_W-1:0] bin);
            lbp_result_t     r;
            int              w;
            int              h;
            int              c;
            int              rw;
            int              thr;
            bit [PIX_W-1:0]  up;
            bit [PIX_W-1:0]  mid;
            bit [CODE_W-1:0] code;
            r.code_valid = 1'b0;
            r.lbp_code   = '0;
            r.frame_done = 1'b0;
            r.bin_count  = '0;
            if (act == ACT_READ)
            begin
                r.bin_count = bin_tally[bin];
                pending_results.push_back(r);
                return;
            end
            w = (roi_w < 1) ? 1 : ((roi_w > MAX_W) ? MAX_W : int'(roi_w));
            h = (roi_h < 1) ? 1 : ((roi_h > MAX_HEIGHT) ? MAX_HEIGHT : int'(roi_h));
            if (sof)
            begin
                foreach (bin_tally[i])
                    bin_tally[i] = '0;
                cur_col = 0;
                cur_row = 0;
            end
            c  = (cur_col >= w) ? w - 1 : cur_col;
            rw = (cur_row >= h) ? h - 1 : cur_row;
            up  = above_line[c];
            mid = near_line[c];
            code = '0;
            if (rw >= 2 && c >= 2)
            begin
                // The centre is the middle row, one column behind the newest pixel.
                thr = int'(mid_win[1]) + int'(delta_reg);
                code[0] = int'(top_win[0]) > thr;
                code[1] = int'(top_win[1]) > thr;
                code[2] = int'(up)         > thr;
                code[3] = int'(mid_win[0]) > thr;
                code[4] = int'(mid)        > thr;
                code[5] = int'(bot_win[0]) > thr;
                code[6] = int'(bot_win[1]) > thr;
                code[7] = int'(pix)        > thr;
                r.code_valid = 1'b1;
                r.lbp_code   = code;
                last_code    = code;
                if (bin_tally[code] != '1)
                    bin_tally[code] = bin_tally[code] + 1'b1;
            end
            top_win[0] = top_win[1];
            top_win[1] = up;
            mid_win[0] = mid_win[1];
            mid_win[1] = mid;
            bot_win[0] = bot_win[1];
            bot_win[1] = pix;
            above_line[c] = mid;
            near_line[c]  = pix;
            if (c + 1 >= w)
            begin
                c = 0;
                if (rw + 1 >= h)
                begin
                    r.frame_done = 1'b1;
                    rw = 0;
                end
                else
                begin
                    rw = rw + 1;
                end
            end
            else
            begin
                c = c + 1;
            end
            cur_col = c;
            cur_row = rw;
            pending_results.push_back(r);
        endfunction

        task report(string what);
            if (errors < MAX_REPORTS)
                $display("MISMATCH at %0t ns: %s", $time, what);
            errors++;
        endtask

        task check_result(logic valid, logic [CODE_W-1:0] code, logic done,
                          logic [COUNT_BITS-1:0] count);
            lbp_result_t want;
            if (pending_results.size() == 0)
            begin
                report($sformatf(
                    "result with nothing pending: valid %0b code %0d done %0b count %0d",
                    valid, code, done, count));
                return;
            end
            want = pending_results.pop_front();
            n_checked++;
            if (valid !== want.code_valid)
                report($sformatf("result %0d code_valid %0b, predicted %0b",
                                 n_checked, valid, want.code_valid));
            if (code !== want.lbp_code)
                report($sformatf("result %0d lbp_code %0d, predicted %0d",
                                 n_checked, code, want.lbp_code));
            if (done !== want.frame_done)
                report($sformatf("result %0d frame_done %0b, predicted %0b",
                                 n_checked, done, want.frame_done));
            if (count !== want.bin_count)
                report($sformatf("result %0d bin_count %0d, predicted %0d",
                                 n_checked, count, want.bin_count));
            if (want.code_valid)
                n_codes++;
            if (want.frame_done)
                n_frames++;
        endtask
    endclass

    logic                     clk           = 1'b0;
    logic                     rst_n         = 1'b0;
    logic                     cfg_we        = 1'b0;
    logic [CFG_ADDR_W-1:0]    cfg_addr      = '0;
    logic [CFG_DATA_W-1:0]    cfg_wdata     = '0;
    logic                     s_axis_tvalid = 1'b0;
    logic                     s_axis_tready;
    logic [IN_DATA_W-1:0]     s_axis_tdata  = '0;
    logic [IN_USER_W-1:0]     s_axis_tuser  = '0;
    logic                     m_axis_tvalid;
    logic                     m_axis_tready = 1'b0;
    logic [OUT_W-1:0]         m_axis_tdata;
    logic                     m_axis_tuser;
    logic                     m_axis_tlast;

    lbp_scoreboard sb;
    int tx_max_gap = 11;
    int rx_max_gap = 11;
    int n_sent     = 0;
    int n_reads    = 0;
    int n_settings = 0;

    lbp_histogram_3x3_unit #(
        .MAX_WIDTH  (MAX_W),
        .COUNT_BITS (COUNT_BITS)
    ) uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Must be entered just after a rising edge; returns at the edge of the transfer
    // with tvalid still high, so the next item can follow without a gap.
    task send_item(logic act, logic sof, logic [PIX_W-1:0] pix, logic [BIN_W-1:0] bin);
        int gap;
        gap = $urandom_range(0, tx_max_gap);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {bin, pix};
        s_axis_tuser  <= {sof, act};
        do @(negedge clk); while (s_axis_tready !== 1'b1);
        sb.add_item(act, sof, pix, bin);
        @(posedge clk);
        n_sent++;
        if (act == ACT_READ)
            n_reads++;
    endtask

    task wait_idle();
        s_axis_tvalid <= 1'b0;
        while (sb.pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_TICKS) @(posedge clk);
    endtask

    task write_config(int d, int w, int h);
        cfg_we    <= 1'b1;
        cfg_addr  <= CFG_DELTA;
        cfg_wdata <= CFG_DATA_W'(d[DELTA_W-1:0]);
        @(posedge clk);
        sb.set_reg(CFG_DELTA, CFG_DATA_W'(d[DELTA_W-1:0]));
        cfg_addr  <= CFG_ROI_WIDTH;
        cfg_wdata <= CFG_DATA_W'(w[RWIDTH_W-1:0]);
        @(posedge clk);
        sb.set_reg(CFG_ROI_WIDTH, CFG_DATA_W'(w[RWIDTH_W-1:0]));
        cfg_addr  <= CFG_ROI_HEIGHT;
        cfg_wdata <= CFG_DATA_W'(h[RHEIGHT_W-1:0]);
        @(posedge clk);
        sb.set_reg(CFG_ROI_HEIGHT, CFG_DATA_W'(h[RHEIGHT_W-1:0]));
        cfg_we <= 1'b0;
        n_settings++;
    endtask

    // Mostly whole frames of random pixels, with bin reads, stray starts of frame,
    // missing starts of frame and the odd pause until the pipeline is empty.
    task run_phase(int n_items, int w, int h);
        int   eff_w;
        int   eff_h;
        int   frame_len;
        int   left;
        int   sent;
        int   roll;
        int   v;
        int   base;
        logic sof;
        bit   first;
        eff_w     = (w < 1) ? 1 : ((w > MAX_W) ? MAX_W : w);
        eff_h     = (h < 1) ? 1 : ((h > MAX_HEIGHT) ? MAX_HEIGHT : h);
        frame_len = eff_w * eff_h;
        left      = 0;
        sent      = 0;
        first     = 1'b1;
        base      = $urandom_range(0, 255);
        while (sent < n_items)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 8 && !first)
            begin
                if ($urandom_range(0, 1) == 0)
                    v = int'(sb.last_code);
                else
                    v = $urandom_range(0, 255);
                send_item(ACT_READ, 1'($urandom_range(0, 1)), PIX_W'($urandom_range(0, 255)),
                          BIN_W'(v));
                sent++;
            end
            else if (roll < 10 && !first)
            begin
                wait_idle();
            end
            else
            begin
                // A phase always opens with a start of frame, so no line store
                // entry is used before this frame has written it.
                if (first)
                    sof = 1'b1;
                else if (left == 0)
                    sof = ($urandom_range(0, 9) != 0);
                else
                    sof = ($urandom_range(0, 49) == 0);
                if (sof || left == 0)
                    left = frame_len;
                left--;
                first = 1'b0;
                case ($urandom_range(0, 3))
                    0, 1: v = $urandom_range(0, 255);
                    2:
                    begin
                        v = base + int'($urandom_range(0, 8)) - 4;
                        v = (v < 0) ? 0 : ((v > 255) ? 255 : v);
                    end
                    default: v = ($urandom_range(0, 1) == 0) ? 0 : 255;
                endcase
                send_item(ACT_PIXEL, sof, PIX_W'(v), BIN_W'($urandom_range(0, 255)));
                sent++;
            end
        end
    endtask

    initial
    begin
        logic [PIX_W-1:0] first_frame [9];
        int p;
        int d;
        int w;
        int h;
        int n;
        sb = new();
        first_frame = '{8'd255, 8'd0, 8'd255, 8'd0, 8'd128, 8'd255, 8'd0, 8'd255, 8'd0};
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Smallest frame, with pixel extremes around a mid-grey centre.
        write_config(0, 3, 3);
        for (int i = 0; i < 9; i++)
            send_item(ACT_PIXEL, i == 0, first_frame[i], 8'hFF);
        send_item(ACT_READ, 1'b1, 8'hFF, 8'd85);
        send_item(ACT_READ, 1'b0, 8'h00, 8'd0);
        send_item(ACT_READ, 1'b1, 8'h00, 8'd255);

        // Offset of -255: every neighbour beats a dark centre. The start
        // of frame must also have cleared the earlier count.
        wait_idle();
        write_config(-255, 3, 3);
        for (int i = 0; i < 9; i++)
            send_item(ACT_PIXEL, i == 0, 8'd0, 8'h00);
        send_item(ACT_READ, 1'b0, 8'hFF, 8'd255);
        send_item(ACT_READ, 1'b0, 8'hFF, 8'd85);

        for (p = 0; p < NUM_PHASES; p++)
        begin
            d = int'($urandom_range(0, 511)) - 256;
            w = $urandom_range(3, 12);
            h = $urandom_range(3, 6);
            n = 116;
            case (p)
                0:  d = 255;
                1:  d = -255;
                2:  d = -256;
                3:
                begin
                    d = 0;
                    w = 40;
                end
                4:  w = 0;
                5:  w = 1;
                6:  w = 2;
                7:
                begin
                    w = 2047;
                    h = 3;
                end
                8:  h = 0;
                9:  h = 1;
                10: h = 8191;
                11: h = 4096;
                default: ;
            endcase
            wait_idle();
            tx_max_gap = ($urandom_range(0, 3) == 0) ? 0 : 11;
            rx_max_gap = ($urandom_range(0, 3) == 0) ? 0 : 11;
            write_config(d, w, h);
            run_phase(n, w, h);
        end

        wait_idle();
        $display("Run covered %0d input transfers (%0d bin reads) over %0d register settings.",
                 n_sent, n_reads, n_settings);
        $display("%0d results checked, %0d codes counted, %0d frame ends, %0d mismatches.",
                 sb.n_checked, sb.n_codes, sb.n_frames, sb.errors);
        if (sb.errors == 0)
            $display("PASS lbp_histogram_3x3_unit");
        else
            $display("FAIL lbp_histogram_3x3_unit");
        $finish;
    end

    // Result side: random stalls ahead of every transfer, checked in order.
    initial
    begin
        int gap;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            gap = $urandom_range(0, rx_max_gap);
            if (gap > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do @(negedge clk); while (m_axis_tvalid !== 1'b1);
            sb.check_result(m_axis_tuser, m_axis_tdata[CODE_W-1:0], m_axis_tlast,
                            m_axis_tdata[CODE_W +: COUNT_BITS]);
            @(posedge clk);
        end
    end

    initial
    begin
        #5_000_000;
        $display("Timed out with %0d results outstanding.", sb.pending_results.size());
        $display("FAIL lbp_histogram_3x3_unit");
        $finish;
    end

endmodule
